@@ rtl/core/gvp_pkg.sv @@
`default_nettype none

package gvp_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAUGE_TYPE    = 2'd0,
        CFG_GAS_KIND      = 2'd1,
        CFG_PRESSURE_UNIT = 2'd2
    } cfg_index_t;

    localparam logic [2:0] GAUGE_ION_MAX    = 3'd1;
    localparam logic [2:0] GAUGE_PIRANI_MAX = 3'd3;
    localparam logic [1:0] GAS_NITROGEN     = 2'd0;
    localparam logic [1:0] GAS_ARGON        = 2'd1;
    localparam logic [1:0] UNIT_MBAR        = 2'd0;
    localparam logic [1:0] UNIT_TORR        = 2'd1;
    localparam logic [1:0] UNIT_PA          = 2'd2;
    localparam logic [1:0] UNIT_BAD         = 2'd3;

    localparam logic [2:0] GAUGE_TYPE_RST    = 3'd0;
    localparam logic [1:0] GAS_KIND_RST      = GAS_NITROGEN;
    localparam logic [1:0] PRESSURE_UNIT_RST = UNIT_PA;

    localparam int FRAC = 28;

    // Voltage scaling: U = s * SCL / DEN, split as s * QT + s * RT / DEN.
    localparam longint unsigned DEN0 = 64'd40650;
    localparam longint unsigned DEN1 = 64'd4055;
    localparam longint unsigned NUM0 = 64'd85 << FRAC;
    localparam longint unsigned NUM1 = 64'd10 << FRAC;
    localparam longint unsigned QT0  = NUM0 / DEN0;
    localparam longint unsigned QT1  = NUM1 / DEN1;
    localparam longint unsigned RT0  = NUM0 % DEN0;
    localparam longint unsigned RT1  = NUM1 % DEN1;
    localparam int QT_W  = 20;
    localparam int RT_W  = 16;
    localparam int DEN_W = 16;
    localparam int D2_W  = 17;

    localparam int UQ_XW = 40;
    localparam int UQS_W = 34;
    localparam longint unsigned UQ_SAT = 64'd52 << FRAC;

    // The ionisation law scales by 1667/1000; the high half of U is folded
    // in exactly, so that only a narrow remainder goes through the divide.
    localparam longint unsigned ION_HI  = (64'd667 << 16) / 64'd1000;
    localparam longint unsigned ION_LO  = (64'd667 << 16) % 64'd1000;
    localparam longint unsigned REC1000 = (64'd1 << FRAC) / 64'd1000;
    localparam int Y_W   = 28;
    localparam int QD_W  = 18;
    localparam int UQH_W = 35;

    localparam int EQ_W  = 37;
    localparam int MAG_W = 34;
    localparam int LQ_W  = 38;
    localparam int E_W   = LQ_W - FRAC;

    localparam longint unsigned OFS_ION   = 64'd2504502804;
    localparam longint unsigned OFS_PIR   = 64'd939524096;
    localparam longint unsigned EXP_CLAMP = 64'd48 << FRAC;
    localparam longint unsigned LOG2_TEN  = 64'd891723283;
    localparam int LOG2_TEN_W = 30;

    localparam logic signed [LQ_W-1:0] GAS_AR_ION = -38'sd86416915;
    localparam logic signed [LQ_W-1:0] GAS_AR_PIR = 38'sd205496669;
    localparam logic signed [LQ_W-1:0] UNIT_MBAR_OFS = -38'sd1783446566;
    localparam logic signed [LQ_W-1:0] UNIT_TORR_OFS = -38'sd1894760517;

    localparam logic [31:0] FLOAT_INF = 32'h7F80_0000;

    // Entry idx of the exponent table: 2^(2^-idx) in Q30, each entry the
    // rounded square root of the one before, starting from 2.0.
    function automatic logic [31:0] gvp_exp_entry(input int idx);
        logic [63:0] prev;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        prev = 64'd1 << 31;
        for (int i = 1; i <= FRAC; i++)
        begin
            if (i <= idx)
            begin
                x = prev << 32;
                r = 64'd0;
                b = 64'd1 << 62;
                for (int j = 0; j < 32; j++)
                begin
                    if (x >= r + b)
                    begin
                        x = x - (r + b);
                        r = (r >> 1) + b;
                    end
                    else
                    begin
                        r = r >> 1;
                    end
                    b = b >> 2;
                end
                prev = (r + 64'd1) >> 1;
            end
        end
        return prev[31:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/gauge_voltage_to_pressure_top.sv @@
`default_nettype none

// Converts one gauge converter sample per clock into an IEEE single-precision
// pressure. A sample is taken on every rising edge with start high (busy is
// always low), and its result appears on pressure_bits and code_invalid with
// done high for exactly one cycle; the results come out in sample order at the
// full clock rate. The pipeline holds the exponent stage, a chain of 28 pipelined
// multipliers that forms 2^f one fractional bit per stage, behind 14 stages of
// voltage scaling and log-domain arithmetic and two stages of rounding and
// packing. There is no back-pressure: the receiver must take each result in the
// cycle it is shown. Configuration writes take effect at once and must only be
// made with no sample in flight.

module gauge_voltage_to_pressure_top
    import gvp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [SAMPLE_BITS-1:0] adc_sample,
    input  wire logic                   channel,
    output logic                        done,
    output logic [31:0]                 pressure_bits,
    output logic                        code_invalid
);

    localparam int SB    = SAMPLE_BITS;
    localparam int NW    = SB + 17;
    localparam int RK    = SB + 17;
    localparam int RMW   = SB + 5;
    localparam int SQW   = SB + QT_W;
    localparam int UQW   = SB + 21;
    localparam int PRE   = 14;
    localparam int LAT   = PRE + FRAC + 2;
    localparam longint unsigned RM0 = (64'd1 << RK) / (64'd2 * DEN0);
    localparam longint unsigned RM1 = (64'd1 << RK) / (64'd2 * DEN1);

    logic [2:0] gauge_type_reg;
    logic [1:0] gas_kind_reg;
    logic [1:0] pressure_unit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gauge_type_reg    <= GAUGE_TYPE_RST;
            gas_kind_reg      <= GAS_KIND_RST;
            pressure_unit_reg <= PRESSURE_UNIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GAUGE_TYPE:    gauge_type_reg    <= cfg_data[2:0];
                CFG_GAS_KIND:      gas_kind_reg      <= cfg_data[1:0];
                CFG_PRESSURE_UNIT: pressure_unit_reg <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    logic ion;
    logic code_bad;
    assign ion      = gauge_type_reg <= GAUGE_ION_MAX;
    assign code_bad = (gauge_type_reg > GAUGE_PIRANI_MAX) || (gas_kind_reg > GAS_ARGON)
                      || (pressure_unit_reg == UNIT_BAD);

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign busy     = 1'b0;
    assign vld_next = {vld_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Voltage scaling.
    logic [QT_W-1:0]  qt_sel;
    logic [RT_W-1:0]  rt_sel;
    logic [DEN_W-1:0] den_sel;
    logic [SQW-1:0]   s1_sq_next, s1_sq_reg;
    logic [NW-1:0]    s1_n_next, s1_n_reg;
    logic             s1_ch_reg;

    assign qt_sel     = channel ? QT_W'(QT1) : QT_W'(QT0);
    assign rt_sel     = channel ? RT_W'(RT1) : RT_W'(RT0);
    assign den_sel    = channel ? DEN_W'(DEN1) : DEN_W'(DEN0);
    assign s1_sq_next = SQW'(adc_sample) * SQW'(qt_sel);
    assign s1_n_next  = NW'({adc_sample, 1'b0}) * NW'(rt_sel) + NW'(den_sel);

    logic [RMW-1:0]    rm_sel;
    logic [NW+RMW-1:0] s2_prod;
    logic [SB:0]       s2_qe_next, s2_qe_reg;
    logic [SQW-1:0]    s2_sq_reg;
    logic [NW-1:0]     s2_n_reg;
    logic              s2_ch_reg;

    assign rm_sel     = s1_ch_reg ? RMW'(RM1) : RMW'(RM0);
    assign s2_prod    = (NW+RMW)'(s1_n_reg) * (NW+RMW)'(rm_sel);
    assign s2_qe_next = s2_prod[RK+SB:RK];

    logic [D2_W-1:0] d2_sel2;
    logic [NW-1:0]   s3_pr_next, s3_pr_reg;
    logic [SB:0]     s3_qe_reg;
    logic [SQW-1:0]  s3_sq_reg;
    logic [NW-1:0]   s3_n_reg;
    logic            s3_ch_reg;

    assign d2_sel2    = s2_ch_reg ? D2_W'(64'd2 * DEN1) : D2_W'(64'd2 * DEN0);
    assign s3_pr_next = NW'(s2_qe_reg) * NW'(d2_sel2);

    logic [D2_W-1:0] d2_sel3;
    logic            s4_corr;
    logic [UQW-1:0]  s4_uq_next, s4_uq_reg;

    assign d2_sel3    = s3_ch_reg ? D2_W'(64'd2 * DEN1) : D2_W'(64'd2 * DEN0);
    assign s4_corr    = (s3_n_reg - s3_pr_reg) >= NW'(d2_sel3);
    assign s4_uq_next = UQW'(s3_sq_reg) + UQW'(s3_qe_reg) + UQW'(s4_corr);

    logic [UQ_XW-1:0] s5_uq_x;
    logic [UQS_W-1:0] s5_uq_next, s5_uq_reg;

    assign s5_uq_x    = UQ_XW'(s4_uq_reg);
    assign s5_uq_next = (s5_uq_x >= UQ_XW'(UQ_SAT)) ? UQS_W'(UQ_SAT) : s5_uq_x[UQS_W-1:0];

    // Decimal exponent of the ionisation law.
    logic [UQS_W-17:0] s6_uh;
    logic [Y_W-1:0]    s6_y_next, s6_y_reg;
    logic [UQH_W-1:0]  s6_uqh_next, s6_uqh_reg;
    logic [UQS_W-1:0]  s6_uq_reg;

    assign s6_uh       = s5_uq_reg[UQS_W-1:16];
    assign s6_y_next   = Y_W'(s6_uh) * Y_W'(ION_LO) + Y_W'(s5_uq_reg[15:0]) * Y_W'(667)
                         + Y_W'(500);
    assign s6_uqh_next = UQH_W'(s5_uq_reg) + UQH_W'(s6_uh) * UQH_W'(ION_HI);

    logic [Y_W+19-1:0] s7_prod;
    logic [QD_W-1:0]   s7_qe_next, s7_qe_reg;
    logic [Y_W-1:0]    s7_y_reg;
    logic [UQH_W-1:0]  s7_uqh_reg;
    logic [UQS_W-1:0]  s7_uq_reg;

    assign s7_prod    = (Y_W+19)'(s6_y_reg) * (Y_W+19)'(REC1000);
    assign s7_qe_next = s7_prod[FRAC+QD_W-1:FRAC];

    logic [Y_W-1:0]   s8_pr_next, s8_pr_reg;
    logic [QD_W-1:0]  s8_qe_reg;
    logic [Y_W-1:0]   s8_y_reg;
    logic [UQH_W-1:0] s8_uqh_reg;
    logic [UQS_W-1:0] s8_uq_reg;

    assign s8_pr_next = Y_W'(s7_qe_reg) * Y_W'(1000);

    logic [QD_W-1:0]  s9_qd_next, s9_qd_reg;
    logic [UQH_W-1:0] s9_uqh_reg;
    logic [UQS_W-1:0] s9_uq_reg;

    assign s9_qd_next = s8_qe_reg + QD_W'((s8_y_reg - s8_pr_reg) >= Y_W'(1000));

    logic [EQ_W-1:0] s10_eq_next, s10_eq_reg;

    assign s10_eq_next = ion ? (EQ_W'(s9_uqh_reg) + EQ_W'(s9_qd_reg) - EQ_W'(OFS_ION))
                             : (EQ_W'(s9_uq_reg) - EQ_W'(OFS_PIR));

    // Clamp, then scale by log2(10) in two partial products.
    logic [EQ_W-1:0]  s11_abs;
    logic [MAG_W-1:0] s11_mag_next, s11_mag_reg;
    logic             s11_neg_reg;

    assign s11_abs      = s10_eq_reg[EQ_W-1] ? (EQ_W'(0) - s10_eq_reg) : s10_eq_reg;
    assign s11_mag_next = (s11_abs > EQ_W'(EXP_CLAMP)) ? MAG_W'(EXP_CLAMP)
                                                      : s11_abs[MAG_W-1:0];

    localparam int PP_W = 17 + LOG2_TEN_W;

    logic [PP_W-1:0] s12_pph_next, s12_pph_reg;
    logic [PP_W-1:0] s12_ppl_next, s12_ppl_reg;
    logic            s12_neg_reg;

    assign s12_pph_next = PP_W'(s11_mag_reg[MAG_W-1:17]) * PP_W'(LOG2_TEN);
    assign s12_ppl_next = PP_W'(s11_mag_reg[16:0]) * PP_W'(LOG2_TEN);

    logic [63:0]       s13_sum;
    logic [LQ_W-3:0]   s13_prod_next, s13_prod_reg;
    logic              s13_neg_reg;

    assign s13_sum       = (64'(s12_pph_reg) << 17) + 64'(s12_ppl_reg) + (64'd1 << (FRAC - 1));
    assign s13_prod_next = s13_sum[63:FRAC];

    logic signed [LQ_W-1:0] s14_base;
    logic signed [LQ_W-1:0] s14_gas;
    logic signed [LQ_W-1:0] s14_unit;
    logic signed [LQ_W-1:0] s14_lq;

    assign s14_base = s13_neg_reg ? -$signed(LQ_W'(s13_prod_reg)) : $signed(LQ_W'(s13_prod_reg));
    assign s14_gas  = (gas_kind_reg == GAS_ARGON) ? (ion ? GAS_AR_ION : GAS_AR_PIR)
                                                  : LQ_W'(0);
    assign s14_lq   = s14_base + s14_gas + s14_unit;

    always_comb
    begin
        unique case (pressure_unit_reg)
            UNIT_MBAR: s14_unit = UNIT_MBAR_OFS;
            UNIT_TORR: s14_unit = UNIT_TORR_OFS;
            default:   s14_unit = '0;
        endcase
    end

    // Exponent chain: stage k multiplies by 2^(2^-k) when fraction bit k is set.
    logic [31:0]           ex_m_reg [0:FRAC];
    logic signed [E_W-1:0] ex_e_reg [0:FRAC];
    logic [FRAC-1:0]       ex_f_reg [0:FRAC];
    logic [31:0]           ex_m_next [1:FRAC];

    for (genvar k = 1; k <= FRAC; k++)
    begin : g_exp
        localparam logic [31:0] TAB = gvp_exp_entry(k);
        logic [63:0] mul;
        assign mul = 64'(ex_m_reg[k-1]) * 64'(TAB) + (64'd1 << 29);
        assign ex_m_next[k] = ex_f_reg[k-1][FRAC-k] ? mul[61:30] : ex_m_reg[k-1];
    end

    // Normalise and round.
    logic [31:0]        s43_m;
    logic signed [10:0] s43_e;
    logic [31:0]        s43_mn_next, s43_mn_reg;
    logic signed [10:0] s43_en;
    logic signed [10:0] s43_bias_next, s43_bias_reg;
    logic signed [10:0] s43_sh_next, s43_sh_reg;
    logic [31:0]        s43_rsum;
    logic [24:0]        s43_mant_next, s43_mant_reg;

    assign s43_m         = ex_m_reg[FRAC];
    assign s43_e         = 11'(ex_e_reg[FRAC]);
    assign s43_mn_next   = s43_m[31] ? (s43_m >> 1) : s43_m;
    assign s43_en        = s43_m[31] ? (s43_e + 11'sd1) : s43_e;
    assign s43_bias_next = s43_en + 11'sd127;
    assign s43_sh_next   = -11'sd119 - s43_en;
    assign s43_rsum      = s43_mn_next + 32'd64;
    assign s43_mant_next = s43_rsum[31:7];

    logic [24:0]        s44_mant;
    logic signed [10:0] s44_bias;
    logic [4:0]         s44_shm1;
    logic [32:0]        s44_rs;
    logic [32:0]        s44_sub;
    logic [31:0]        s44_bits;
    logic [31:0]        out_bits_reg;
    logic               out_inv_reg;

    assign s44_mant = s43_mant_reg[24] ? (s43_mant_reg >> 1) : s43_mant_reg;
    assign s44_bias = s43_mant_reg[24] ? (s43_bias_reg + 11'sd1) : s43_bias_reg;
    assign s44_shm1 = 5'(s43_sh_reg[4:0] - 5'd1);
    assign s44_rs   = 33'(s43_mn_reg) + (33'd1 << s44_shm1);
    assign s44_sub  = s44_rs >> s43_sh_reg[4:0];

    always_comb
    begin
        if (code_bad)
        begin
            s44_bits = '0;
        end
        else if (s43_bias_reg > 11'sd0)
        begin
            if (s44_bias >= 11'sd255)
            begin
                s44_bits = FLOAT_INF;
            end
            else
            begin
                s44_bits = {1'b0, s44_bias[7:0], s44_mant[22:0]};
            end
        end
        else if (s43_sh_reg > 11'sd31)
        begin
            s44_bits = '0;
        end
        else
        begin
            s44_bits = s44_sub[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sq_reg    <= s1_sq_next;
        s1_n_reg     <= s1_n_next;
        s1_ch_reg    <= channel;
        s2_qe_reg    <= s2_qe_next;
        s2_sq_reg    <= s1_sq_reg;
        s2_n_reg     <= s1_n_reg;
        s2_ch_reg    <= s1_ch_reg;
        s3_pr_reg    <= s3_pr_next;
        s3_qe_reg    <= s2_qe_reg;
        s3_sq_reg    <= s2_sq_reg;
        s3_n_reg     <= s2_n_reg;
        s3_ch_reg    <= s2_ch_reg;
        s4_uq_reg    <= s4_uq_next;
        s5_uq_reg    <= s5_uq_next;
        s6_y_reg     <= s6_y_next;
        s6_uqh_reg   <= s6_uqh_next;
        s6_uq_reg    <= s5_uq_reg;
        s7_qe_reg    <= s7_qe_next;
        s7_y_reg     <= s6_y_reg;
        s7_uqh_reg   <= s6_uqh_reg;
        s7_uq_reg    <= s6_uq_reg;
        s8_pr_reg    <= s8_pr_next;
        s8_qe_reg    <= s7_qe_reg;
        s8_y_reg     <= s7_y_reg;
        s8_uqh_reg   <= s7_uqh_reg;
        s8_uq_reg    <= s7_uq_reg;
        s9_qd_reg    <= s9_qd_next;
        s9_uqh_reg   <= s8_uqh_reg;
        s9_uq_reg    <= s8_uq_reg;
        s10_eq_reg   <= s10_eq_next;
        s11_mag_reg  <= s11_mag_next;
        s11_neg_reg  <= s10_eq_reg[EQ_W-1];
        s12_pph_reg  <= s12_pph_next;
        s12_ppl_reg  <= s12_ppl_next;
        s12_neg_reg  <= s11_neg_reg;
        s13_prod_reg <= s13_prod_next;
        s13_neg_reg  <= s12_neg_reg;
        ex_m_reg[0]  <= 32'd1 << 30;
        ex_e_reg[0]  <= s14_lq[LQ_W-1:FRAC];
        ex_f_reg[0]  <= s14_lq[FRAC-1:0];
        for (int k = 1; k <= FRAC; k++)
        begin
            ex_m_reg[k] <= ex_m_next[k];
            ex_e_reg[k] <= ex_e_reg[k-1];
            ex_f_reg[k] <= ex_f_reg[k-1];
        end
        s43_mn_reg   <= s43_mn_next;
        s43_bias_reg <= s43_bias_next;
        s43_sh_reg   <= s43_sh_next;
        s43_mant_reg <= s43_mant_next;
        out_bits_reg <= s44_bits;
        out_inv_reg  <= code_bad;
    end

    assign done          = vld_reg[LAT-1];
    assign pressure_bits = out_bits_reg;
    assign code_invalid  = out_inv_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result beat without a sample taken at the pipeline depth");

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && code_invalid) |-> (pressure_bits == 32'd0))
        else $error("invalid code beat carries a non-zero pressure");

    a_never_negative: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !pressure_bits[31])
        else $error("pressure beat has the sign bit set");

    a_never_nan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((pressure_bits[30:23] != 8'hFF) || (pressure_bits[22:0] == 23'd0)))
        else $error("pressure beat is not a number");

endmodule

`default_nettype wire
